/* rtl/core/bdph_pkg.sv */
package bdph_pkg;

	// Width of the pressed sample counter, 8 to 32.
	localparam int COUNT_WIDTH = 16;
	localparam int HOLD_W      = 16;
	localparam int DEB_W       = 8;
	localparam int CMP_W       = (COUNT_WIDTH > HOLD_W) ? COUNT_WIDTH : HOLD_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD        = 2'd2;

	localparam logic             RST_ACTIVE_LOW = 1'b1;
	localparam logic [DEB_W-1:0]  RST_DEBOUNCE  = 8'd8;
	localparam logic [HOLD_W-1:0] RST_HOLD      = 16'd1000;

	typedef enum logic [1:0] {
		BTN_UNKNOWN  = 2'd0,
		BTN_PRESSED  = 2'd1,
		BTN_RELEASED = 2'd2
	} btn_state_t;

	typedef struct packed {
		logic              active_low;
		logic [DEB_W-1:0]  debounce_threshold;
		logic [HOLD_W-1:0] hold_threshold;
	} cfg_t;

	typedef struct packed {
		btn_state_t state;
		logic       press_event;
		logic       hold_event;
		logic       release_event;
	} result_t;

endpackage

/* rtl/core/bdph_in_if.sv */
interface bdph_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

/* rtl/core/bdph_out_if.sv */
interface bdph_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] button_state;
	logic       press_event;
	logic       hold_event;
	logic       release_event;

	modport source (
		output valid, output button_state, output press_event,
		output hold_event, output release_event, input ready
	);
	modport sink (
		input valid, input button_state, input press_event,
		input hold_event, input release_event, output ready
	);
endinterface

/* rtl/core/bdph_core.sv */
module bdph_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             pin,
	input  bdph_pkg::cfg_t   cfg,
	output bdph_pkg::result_t res
);

	localparam logic [bdph_pkg::COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic                             last_q, last_n;
	logic [bdph_pkg::COUNT_WIDTH-1:0] pcnt_q, pcnt_n, pcnt_inc;
	logic [bdph_pkg::DEB_W-1:0]       rcnt_q, rcnt_n;
	logic                             press_rep_q, press_rep_n;
	logic                             hold_rep_q, hold_rep_n;
	logic                             rel_rep_q, rel_rep_n;
	logic                             cur;

	assign cur      = pin ^ cfg.active_low;
	assign pcnt_inc = (pcnt_q != CNT_MAX) ? pcnt_q + 1'b1 : pcnt_q;

	always_comb begin
		last_n      = cur;
		pcnt_n      = pcnt_q;
		rcnt_n      = rcnt_q;
		press_rep_n = press_rep_q;
		hold_rep_n  = hold_rep_q;
		rel_rep_n   = rel_rep_q;
		res         = '0;
		res.state   = bdph_pkg::BTN_UNKNOWN;
		if (cur != last_q) begin
			pcnt_n      = '0;
			rcnt_n      = '0;
			press_rep_n = 1'b0;
			hold_rep_n  = 1'b0;
			rel_rep_n   = 1'b0;
		end else if (cur) begin
			pcnt_n = pcnt_inc;
			if (pcnt_inc >= bdph_pkg::COUNT_WIDTH'(cfg.debounce_threshold)) begin
				res.state = bdph_pkg::BTN_PRESSED;
				if (!press_rep_q) begin
					res.press_event = 1'b1;
					press_rep_n     = 1'b1;
				end
				if (!hold_rep_q && bdph_pkg::CMP_W'(pcnt_inc) >=
						bdph_pkg::CMP_W'(cfg.hold_threshold)) begin
					res.hold_event = 1'b1;
					hold_rep_n     = 1'b1;
				end
			end
		end else begin
			if (rcnt_q < cfg.debounce_threshold) begin
				rcnt_n = rcnt_q + 1'b1;
			end else begin
				res.state = bdph_pkg::BTN_RELEASED;
				if (!rel_rep_q) begin
					res.release_event = 1'b1;
					rel_rep_n         = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			pcnt_q      <= '0;
			rcnt_q      <= '0;
			press_rep_q <= 1'b0;
			hold_rep_q  <= 1'b0;
			rel_rep_q   <= 1'b0;
		end else if (step) begin
			last_q      <= last_n;
			pcnt_q      <= pcnt_n;
			rcnt_q      <= rcnt_n;
			press_rep_q <= press_rep_n;
			hold_rep_q  <= hold_rep_n;
			rel_rep_q   <= rel_rep_n;
		end
	end

	// hold is only ever flagged together with or after the press report
	a_hold_after_press: assert property (@(posedge clk) disable iff (!arst_n)
		hold_rep_q |-> press_rep_q)
		else $error("hold flag set without press flag");

	a_change_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && (cur != last_q) |=> pcnt_q == '0 && rcnt_q == '0 && !press_rep_q)
		else $error("level change did not clear counters");

	a_press_once: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.press_event |=> press_rep_q)
		else $error("press event did not set press flag");

	a_release_flag: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.release_event |=> rel_rep_q && !last_q)
		else $error("release event bookkeeping wrong");

endmodule

/* rtl/core/button_debounce_press_hold.sv */
// Button debouncer with press, hold and release events.
//
// in_ch carries one raw pin sample per transfer; out_ch returns exactly one
// result per sample: debounced state (unknown / pressed / released) and
// one-shot press, hold and release pulses.
// Configuration (polarity, debounce and hold thresholds) is written through
// cfg_we / cfg_index / cfg_data; write it only while no sample is in flight.
// Unknown indexes are ignored.
//
// A sample accepted by in_ch is held in the input register; its result is
// loaded into the output register once that register is empty or being read
// by out_ch, and is visible from then on, with out_ch.valid high. Throughput
// is one sample per cycle while out_ch does not stall, set by the counter
// update between the two registers.
// When out_ch stalls the result holds, one further sample waits in the input
// register, and in_ch.ready drops until out_ch takes the result.
// Reset clears counters and flags, empties both registers and loads the
// default configuration (active low, debounce 8, hold 1000).
module button_debounce_press_hold (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bdph_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bdph_pkg::CFG_DATA_W-1:0]   cfg_data,
	bdph_in_if.sink                           in_ch,
	bdph_out_if.source                        out_ch
);

	bdph_pkg::cfg_t    cfg_q;
	bdph_pkg::result_t res, res_q;
	logic              valid_s1, pin_s1;
	logic              out_valid_q;
	logic              advance;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low         <= bdph_pkg::RST_ACTIVE_LOW;
			cfg_q.debounce_threshold <= bdph_pkg::RST_DEBOUNCE;
			cfg_q.hold_threshold     <= bdph_pkg::RST_HOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdph_pkg::CFG_ACTIVE_LOW: cfg_q.active_low <= cfg_data[0];
				bdph_pkg::CFG_DEBOUNCE:
					cfg_q.debounce_threshold <= cfg_data[bdph_pkg::DEB_W-1:0];
				bdph_pkg::CFG_HOLD:
					cfg_q.hold_threshold <= cfg_data[bdph_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready)
				valid_s1 <= in_ch.valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			pin_s1 <= in_ch.pin_level;
		if (advance)
			res_q <= res;
	end

	bdph_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.pin    (pin_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign out_ch.valid         = out_valid_q;
	assign out_ch.button_state  = res_q.state;
	assign out_ch.press_event   = res_q.press_event;
	assign out_ch.hold_event    = res_q.hold_event;
	assign out_ch.release_event = res_q.release_event;

endmodule
